### hdl/event_rate_meter_with_fixed_step_assert.svh
// assertion macros for the event rate meter checker
// expects signals named clk and arst_n in the scope of each use
`ifndef EVENT_RATE_METER_WITH_FIXED_STEP_ASSERT_SVH
`define EVENT_RATE_METER_WITH_FIXED_STEP_ASSERT_SVH

// consequent checked in the same cycle
`define ERM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define ERM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/erm_pkg.sv
// shared types and constants of the event rate meter
// no dependencies
package erm_pkg;

	typedef enum logic [1:0] {
		REQ_UPDATE = 2'd0,
		REQ_FRAME  = 2'd1,
		REQ_CHECK  = 2'd2,
		REQ_OTHER  = 2'd3
	} erm_req_t;

	typedef enum logic [1:0] {
		CFG_UPDATE_PERIOD = 2'd0,
		CFG_MIN_INTERVAL  = 2'd1
	} erm_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_CLAMP,
		ST_DIV,
		ST_BLEND,
		ST_BWAIT,
		ST_FIN
	} erm_state_t;

	localparam int CFG_W  = 20;
	localparam int RATE_W = 24;
	localparam int CNT_W  = 32;
	localparam int DEN_W  = 37;
	localparam int QUO_W  = 24;

	localparam logic [CFG_W-1:0] PERIOD_RESET = 20'd16666;
	localparam logic [CFG_W-1:0] MIN_RESET    = 20'd5000;

	// 1e6 in Q16: dividend of the reciprocal
	localparam logic [35:0] RATE_NUM = 36'd65536000000;
	localparam logic [DEN_W-1:0] RATE_NUM_HI = DEN_W'(RATE_NUM >> QUO_W);
	localparam logic [QUO_W-1:0] RATE_NUM_LO = RATE_NUM[QUO_W-1:0];
	// any divisor at or above this gives a zero quotient
	localparam logic [DEN_W-1:0] DEN_CAP = 37'h10_0000_0000;
	// intervals below this saturate the rate
	localparam int SAT_SPAN = 5000;

	localparam logic [RATE_W-1:0] RATE_MAX   = 24'd13107200;
	localparam logic [RATE_W-1:0] RATE_RESET = 24'd3932160;
	localparam logic signed [12:0] ALPHA = 13'sd3277;
	localparam logic signed [37:0] ROUND_HALF = 38'sd32768;

	// status of a multi-cycle unit
	typedef struct packed {
		logic busy;
		logic done;
	} erm_unit_st_t;

endpackage

### hdl/erm_div.sv
// bit-serial restoring divider: 65536e6 / divisor, one quotient bit per cycle
// depends on erm_pkg
module erm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [erm_pkg::DEN_W-1:0]     divisor,
	output logic [erm_pkg::QUO_W-1:0]     quotient,
	output erm_pkg::erm_unit_st_t         status
);

	logic [erm_pkg::DEN_W-1:0] rem_q;
	logic [erm_pkg::DEN_W-1:0] den_q;
	logic [erm_pkg::QUO_W-1:0] dvd_q;
	logic [erm_pkg::QUO_W-1:0] quo_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [erm_pkg::DEN_W-1:0] trial;
	logic                      fits;

	// remainder stays below the divisor, so its top bit is free for the shift
	assign trial = {rem_q[erm_pkg::DEN_W-2:0], dvd_q[erm_pkg::QUO_W-1]};
	assign fits  = trial >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(erm_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= erm_pkg::RATE_NUM_HI;
			dvd_q <= erm_pkg::RATE_NUM_LO;
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial - den_q : trial;
			dvd_q <= {dvd_q[erm_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[erm_pkg::QUO_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### hdl/erm_ema.sv
// exponential average step: avg + round((rate - avg) * 3277 / 65536)
// depends on erm_pkg; two register stages
module erm_ema (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [erm_pkg::RATE_W-1:0]     avg,
	input  logic [erm_pkg::RATE_W-1:0]     rate,
	output logic [erm_pkg::RATE_W-1:0]     result,
	output erm_pkg::erm_unit_st_t          status
);

	logic signed [24:0]              diff;
	logic signed [37:0]              prod_s1;
	logic [erm_pkg::RATE_W-1:0]      avg_s1;
	logic                            vld_s1;
	logic signed [37:0]              rnd;
	logic signed [25:0]              sum;
	logic [erm_pkg::RATE_W-1:0]      result_q;
	logic                            done_q;

	assign diff = $signed({1'b0, rate}) - $signed({1'b0, avg});
	// s*(65536-a) + r*a == (s << 16) + (r - s)*a
	assign rnd  = prod_s1 + erm_pkg::ROUND_HALF;
	assign sum  = $signed({2'b00, avg_s1}) + $signed(rnd[37:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= diff * erm_pkg::ALPHA;
			avg_s1  <= avg;
		end
		if (vld_s1) begin
			result_q <= sum[erm_pkg::RATE_W-1:0];
		end
	end

	assign result      = result_q;
	assign status.busy = vld_s1;
	assign status.done = done_q;

endmodule

### hdl/event_rate_meter_with_fixed_step.sv
// event rate meter with fixed update step: top level, sequencer and state
// depends on erm_pkg, erm_div, erm_ema
//
// One item is in work at a time. A time check (req_type 2 or 3) goes from acceptance
// straight to the output register load and the result transaction. An update or frame
// mark passes interval, clamp, the bit-serial reciprocal divider (24 quotient bits, then
// the quotient handed over), averaging, the output register load and the result
// transaction. Marks whose clamped interval is under 5000 us skip the divider.
// The next item is taken while a finished result waits on the output register.
module event_rate_meter_with_fixed_step #(
	parameter int TIME_BITS = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_addr,
	input  logic [erm_pkg::CFG_W-1:0]         cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((TIME_BITS+7)/8)*8-1:0]    s_tdata,  // now_us
	input  logic [1:0]                        s_tuser,  // req_type
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// update_total, frame_total, instant_rate, smooth_update_rate,
	// smooth_frame_rate, update_due, wait_us
	output logic [((137+TIME_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int OUT_W = ((137 + TIME_BITS + 7) / 8) * 8;
	localparam int SPW   = (TIME_BITS > erm_pkg::DEN_W) ? TIME_BITS : erm_pkg::DEN_W;

	erm_pkg::erm_state_t state_q, state_d;

	logic [erm_pkg::CFG_W-1:0]  period_q;
	logic [erm_pkg::CFG_W-1:0]  min_q;

	logic [erm_pkg::CNT_W-1:0]  upd_cnt_q;
	logic [erm_pkg::CNT_W-1:0]  frm_cnt_q;
	logic [TIME_BITS-1:0]       last_upd_q;
	logic [TIME_BITS-1:0]       last_frm_q;
	logic [TIME_BITS-1:0]       next_upd_q;
	logic [erm_pkg::RATE_W-1:0] sm_upd_q;
	logic [erm_pkg::RATE_W-1:0] sm_frm_q;

	logic [TIME_BITS-1:0]       now_q;
	logic                       mark_q;
	logic                       is_upd_q;
	logic [TIME_BITS-1:0]       span_q;
	logic [erm_pkg::RATE_W-1:0] rate_q;

	logic                       out_vld_q;
	logic [erm_pkg::CNT_W-1:0]  o_upd_q;
	logic [erm_pkg::CNT_W-1:0]  o_frm_q;
	logic [erm_pkg::RATE_W-1:0] o_inst_q;
	logic [erm_pkg::RATE_W-1:0] o_su_q;
	logic [erm_pkg::RATE_W-1:0] o_sf_q;
	logic                       o_due_q;
	logic [TIME_BITS-1:0]       o_wait_q;

	logic                       in_acc;
	logic                       in_mark;
	logic                       in_upd;
	logic [TIME_BITS-1:0]       in_now;
	logic [TIME_BITS-1:0]       last_sel;
	logic [erm_pkg::CFG_W-1:0]  floor_us;
	logic [TIME_BITS-1:0]       floor_ext;
	logic [TIME_BITS-1:0]       dspan;
	logic [SPW-1:0]             dspan_ext;
	logic [erm_pkg::DEN_W-1:0]  divisor;
	logic                       sat;
	logic                       out_free;

	logic                       div_start;
	logic                       ema_start;
	logic                       out_load;
	logic [erm_pkg::QUO_W-1:0]  div_quo;
	erm_pkg::erm_unit_st_t      div_st;
	logic [erm_pkg::RATE_W-1:0] ema_res;
	erm_pkg::erm_unit_st_t      ema_st;

	assign in_acc  = s_tvalid && s_tready;
	assign in_now  = s_tdata[TIME_BITS-1:0];
	assign in_upd  = s_tuser == erm_pkg::REQ_UPDATE;
	assign in_mark = (s_tuser == erm_pkg::REQ_UPDATE) || (s_tuser == erm_pkg::REQ_FRAME);

	// interval and clamping
	assign last_sel  = is_upd_q ? last_upd_q : last_frm_q;
	assign floor_us  = (min_q == '0) ? erm_pkg::CFG_W'(1) : min_q;
	assign floor_ext = TIME_BITS'(floor_us);
	assign dspan     = (span_q < floor_ext) ? floor_ext : span_q;
	assign dspan_ext = SPW'(dspan);
	assign sat       = dspan < TIME_BITS'(erm_pkg::SAT_SPAN);
	assign divisor   = (|dspan_ext[SPW-1:erm_pkg::DEN_W-1]) ? erm_pkg::DEN_CAP
	                                                       : dspan_ext[erm_pkg::DEN_W-1:0];

	assign out_free = !out_vld_q || m_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= erm_pkg::PERIOD_RESET;
			min_q    <= erm_pkg::MIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				erm_pkg::CFG_UPDATE_PERIOD: period_q <= cfg_wdata;
				erm_pkg::CFG_MIN_INTERVAL:  min_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			erm_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = in_mark ? erm_pkg::ST_SPAN : erm_pkg::ST_FIN;
			end
			erm_pkg::ST_SPAN:  state_d = erm_pkg::ST_CLAMP;
			erm_pkg::ST_CLAMP: state_d = sat ? erm_pkg::ST_BLEND : erm_pkg::ST_DIV;
			erm_pkg::ST_DIV: begin
				if (div_st.done) state_d = erm_pkg::ST_BLEND;
			end
			erm_pkg::ST_BLEND: state_d = erm_pkg::ST_BWAIT;
			erm_pkg::ST_BWAIT: begin
				if (ema_st.done) state_d = erm_pkg::ST_FIN;
			end
			erm_pkg::ST_FIN: begin
				if (out_free) state_d = erm_pkg::ST_IDLE;
			end
			default: state_d = erm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		ema_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			erm_pkg::ST_IDLE:  s_tready  = 1'b1;
			erm_pkg::ST_CLAMP: div_start = !sat;
			erm_pkg::ST_BLEND: ema_start = 1'b1;
			erm_pkg::ST_FIN:   out_load  = out_free;
			default: ;
		endcase
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_cnt_q  <= '0;
			frm_cnt_q  <= '0;
			last_upd_q <= '0;
			last_frm_q <= '0;
			next_upd_q <= '0;
			sm_upd_q   <= erm_pkg::RATE_RESET;
			sm_frm_q   <= erm_pkg::RATE_RESET;
		end else begin
			if (in_acc && in_upd) begin
				upd_cnt_q  <= upd_cnt_q + erm_pkg::CNT_W'(1);
				next_upd_q <= next_upd_q + TIME_BITS'(period_q);
			end
			if (in_acc && s_tuser == erm_pkg::REQ_FRAME) begin
				frm_cnt_q <= frm_cnt_q + erm_pkg::CNT_W'(1);
			end
			if (state_q == erm_pkg::ST_SPAN) begin
				if (is_upd_q) last_upd_q <= now_q;
				else          last_frm_q <= now_q;
			end
			if (state_q == erm_pkg::ST_BWAIT && ema_st.done) begin
				if (is_upd_q) sm_upd_q <= ema_res;
				else          sm_frm_q <= ema_res;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q    <= in_now;
			mark_q   <= in_mark;
			is_upd_q <= in_upd;
		end
		if (state_q == erm_pkg::ST_SPAN) begin
			// time going backwards counts as a zero interval
			span_q <= (now_q >= last_sel) ? now_q - last_sel : '0;
		end
		if (state_q == erm_pkg::ST_CLAMP && sat) begin
			rate_q <= erm_pkg::RATE_MAX;
		end
		if (state_q == erm_pkg::ST_DIV && div_st.done) begin
			rate_q <= div_quo;
		end
	end

	erm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.quotient (div_quo),
		.status   (div_st)
	);

	erm_ema u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ema_start),
		.avg    (is_upd_q ? sm_upd_q : sm_frm_q),
		.rate   (rate_q),
		.result (ema_res),
		.status (ema_st)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_upd_q  <= upd_cnt_q;
			o_frm_q  <= frm_cnt_q;
			o_inst_q <= mark_q ? rate_q : '0;
			o_su_q   <= sm_upd_q;
			o_sf_q   <= sm_frm_q;
			o_due_q  <= next_upd_q < now_q;
			o_wait_q <= (next_upd_q > now_q) ? next_upd_q - now_q : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'({o_wait_q, o_due_q, o_sf_q, o_su_q, o_inst_q, o_frm_q, o_upd_q});

endmodule

### hdl/erm_check.sv
// port-level checker for the event rate meter, bound to the top level
// depends on erm_pkg and event_rate_meter_with_fixed_step_assert.svh
`include "event_rate_meter_with_fixed_step_assert.svh"

module erm_check #(
	parameter int TIME_BITS = 40
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((137+TIME_BITS+7)/8)*8-1:0]    m_tdata
);

	localparam int DUE_BIT = 136;
	localparam int WAIT_LO = 137;
	localparam int WAIT_HI = 136 + TIME_BITS;

	// stalled result holds
	`ERM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// one transaction in work at a time
	`ERM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

	// a due update never has a wait left
	`ERM_ASSERT_NOW(a_due_wait, m_tvalid && m_tdata[DUE_BIT], m_tdata[WAIT_HI:WAIT_LO] == '0, "update due with nonzero wait")

	// rates stay within the saturation limit
	`ERM_ASSERT_NOW(a_rate_max, m_tvalid, (m_tdata[87:64] <= erm_pkg::RATE_MAX) && (m_tdata[111:88] <= erm_pkg::RATE_MAX) && (m_tdata[135:112] <= erm_pkg::RATE_MAX), "rate above limit")

endmodule

bind event_rate_meter_with_fixed_step erm_check #(.TIME_BITS(TIME_BITS)) u_erm_check (.*);

### tb/event_rate_meter_with_fixed_step_test.sv
// self-checking testbench for event_rate_meter_with_fixed_step: directed and random
// timestamped events, an in-bench model of counts, rates, averages and the schedule
// depends on erm_pkg and the event_rate_meter_with_fixed_step rtl
module event_rate_meter_with_fixed_step_test;
	timeunit 1ns;
	timeprecision 1ps;
	import erm_pkg::*;

	localparam int STAMP_W = 40;
	localparam int OUT_W = 184;
	localparam int FIELDS_W = 177;
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;
	localparam logic [63:0] EMA_KEEP = 64'd62259;
	localparam logic [63:0] EMA_TAKE = 64'd3277;
	localparam logic [63:0] EMA_ROUND = 64'd32768;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
	localparam int GAP_MAX = 16;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 105;
	localparam int REPORT_CAP = 200;

	typedef struct packed {
		erm_req_t           kind;
		logic [STAMP_W-1:0] stamp;
	} meter_event_t;

	// packed from the top down, so update count lands in the lowest bits
	typedef struct packed {
		logic [STAMP_W-1:0] wait_us;
		logic               due;
		logic [RATE_W-1:0]  frame_avg;
		logic [RATE_W-1:0]  update_avg;
		logic [RATE_W-1:0]  instant;
		logic [CNT_W-1:0]   frames;
		logic [CNT_W-1:0]   updates;
	} meter_reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [STAMP_W-1:0]   s_tdata = '0;   // now_us
	logic [1:0]           s_tuser = '0;   // req_type
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// update_total, frame_total, instant_rate, smooth_update_rate,
	// smooth_frame_rate, update_due, wait_us, zero pad
	logic [OUT_W-1:0]     m_tdata;

	event_rate_meter_with_fixed_step #(
		.TIME_BITS(STAMP_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial forever #10 clk = ~clk;

	// model copy of registers and state
	logic [CFG_W-1:0]   period_reg;
	logic [CFG_W-1:0]   floor_reg;
	logic [CNT_W-1:0]   updates_seen;
	logic [CNT_W-1:0]   frames_seen;
	logic [STAMP_W-1:0] last_update_at;
	logic [STAMP_W-1:0] last_frame_at;
	logic [STAMP_W-1:0] next_update_at;
	logic [RATE_W-1:0]  avg_update;
	logic [RATE_W-1:0]  avg_frame;

	meter_event_t   event_backlog[$];
	meter_reading_t expected_readings[$];
	meter_event_t   on_offer;
	meter_reading_t want;
	meter_reading_t got;
	logic           in_taken = 1'b0;
	logic           out_taken = 1'b0;

	int failures = 0;
	int readings_checked = 0;
	int settings_used = 0;
	int n_update = 0;
	int n_frame = 0;
	int n_check = 0;
	int n_due = 0;
	int n_ceiling = 0;

	int send_gap = 0;
	int hold_left = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	bit hold_done = 1'b0;

	function automatic logic [RATE_W-1:0] rate_over(logic [STAMP_W-1:0] now,
			logic [STAMP_W-1:0] prev);
		logic [63:0] span;
		logic [63:0] lim;
		logic [63:0] q;
		// time running backwards counts as no time at all
		span = (now >= prev) ? 64'(now - prev) : 64'd0;
		lim = (floor_reg == '0) ? 64'd1 : 64'(floor_reg);
		if (span < lim)
			span = lim;
		q = 64'(RATE_NUM) / span;
		if (q > 64'(RATE_MAX))
			q = 64'(RATE_MAX);
		return q[RATE_W-1:0];
	endfunction

	function automatic logic [RATE_W-1:0] smooth(logic [RATE_W-1:0] avg,
			logic [RATE_W-1:0] rate);
		logic [63:0] acc;
		acc = 64'(avg) * EMA_KEEP + 64'(rate) * EMA_TAKE + EMA_ROUND;
		return acc[16 +: RATE_W];
	endfunction

	function automatic meter_reading_t apply_event(meter_event_t ev);
		meter_reading_t r;
		r = '0;
		case (ev.kind)
		REQ_UPDATE: begin
			updates_seen = updates_seen + 1'b1;
			r.instant = rate_over(ev.stamp, last_update_at);
			last_update_at = ev.stamp;
			avg_update = smooth(avg_update, r.instant);
			next_update_at = next_update_at + STAMP_W'(period_reg);
		end
		REQ_FRAME: begin
			frames_seen = frames_seen + 1'b1;
			r.instant = rate_over(ev.stamp, last_frame_at);
			last_frame_at = ev.stamp;
			avg_frame = smooth(avg_frame, r.instant);
		end
		default: ;
		endcase
		r.updates = updates_seen;
		r.frames = frames_seen;
		r.update_avg = avg_update;
		r.frame_avg = avg_frame;
		r.due = (next_update_at < ev.stamp);
		r.wait_us = (next_update_at > ev.stamp) ? next_update_at - ev.stamp : '0;
		return r;
	endfunction

	function automatic void compare_field(string field, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			failures++;
			// keep the log readable when everything goes wrong
			if (failures <= REPORT_CAP)
				$display("%0t: %s expected %0d got %0d", $time, field, exp, act);
		end
	endfunction

	// results first, then the input transaction of the same edge
	always @(posedge clk) begin
		out_taken = arst_n && m_tvalid && m_tready;
		in_taken = arst_n && s_tvalid && s_tready;
		if (out_taken) begin
			readings_checked++;
			got = meter_reading_t'(m_tdata[FIELDS_W-1:0]);
			if (expected_readings.size() == 0) begin
				failures++;
				$display("%0t: result with none expected, expected nothing got %h", $time,
					m_tdata);
			end else begin
				want = expected_readings.pop_front();
				if (want.due)
					n_due++;
				if (want.instant == RATE_MAX)
					n_ceiling++;
				compare_field("update_total", 64'(want.updates), 64'(got.updates));
				compare_field("frame_total", 64'(want.frames), 64'(got.frames));
				compare_field("instant_rate", 64'(want.instant), 64'(got.instant));
				compare_field("smooth_update_rate", 64'(want.update_avg),
					64'(got.update_avg));
				compare_field("smooth_frame_rate", 64'(want.frame_avg), 64'(got.frame_avg));
				compare_field("update_due", 64'(want.due), 64'(got.due));
				compare_field("wait_us", 64'(want.wait_us), 64'(got.wait_us));
				compare_field("pad bits", 64'd0, 64'(m_tdata[OUT_W-1:FIELDS_W]));
			end
		end
		if (in_taken) begin
			case (on_offer.kind)
			REQ_UPDATE: n_update++;
			REQ_FRAME: n_frame++;
			default: n_check++;
			endcase
			expected_readings.push_back(apply_event(on_offer));
		end
	end

	// event sender
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (in_taken) begin
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (event_backlog.size() > 0) begin
				on_offer = event_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= on_offer.stamp;
				s_tuser <= on_offer.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (out_taken) begin
				// one long hold-off while plenty of events are still queued
				if (!hold_done && readings_checked > 300 && event_backlog.size() > 20) begin
					hold_left = LONG_HOLD;
					hold_done = 1'b1;
				end else begin
					if ($urandom_range(0, 39) == 0)
						recv_calm = !recv_calm;
					hold_left = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic reset_model();
		period_reg = PERIOD_RESET;
		floor_reg = MIN_RESET;
		updates_seen = '0;
		frames_seen = '0;
		last_update_at = '0;
		last_frame_at = '0;
		next_update_at = '0;
		avg_update = RATE_RESET;
		avg_frame = RATE_RESET;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_UPDATE_PERIOD)
			period_reg = val;
		else if (idx == CFG_MIN_INTERVAL)
			floor_reg = val;
		settings_used++;
	endtask

	task automatic push(input erm_req_t kind, input logic [STAMP_W-1:0] stamp);
		meter_event_t ev;
		ev.kind = kind;
		ev.stamp = stamp;
		event_backlog.push_back(ev);
	endtask

	// waits until every event is sent, every reading is back and the block has gone quiet
	task automatic settle();
		while (event_backlog.size() != 0 || expected_readings.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0]   period_pick;
		logic [CFG_W-1:0]   floor_pick;
		logic [STAMP_W-1:0] t;
		logic [63:0]        wide;
		int                 step_max;
		int                 roll;

		reset_model();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: saturation, exact ceiling, backwards time, unknown kind, extremes
		push(REQ_CHECK, '0);
		push(REQ_UPDATE, '0);
		push(REQ_UPDATE, 40'd16666);
		push(REQ_CHECK, 40'd10000);
		push(REQ_FRAME, 40'd5000);
		push(REQ_FRAME, 40'd4000);
		push(REQ_FRAME, 40'd21667);
		push(REQ_OTHER, 40'd40000);
		push(REQ_CHECK, STAMP_MAX);
		push(REQ_FRAME, STAMP_MAX);
		push(REQ_UPDATE, STAMP_MAX);
		push(REQ_UPDATE, '0);
		settle();

		// zero minimum acts as one, zero period freezes the schedule
		write_reg(CFG_MIN_INTERVAL, '0);
		write_reg(CFG_UPDATE_PERIOD, '0);
		push(REQ_UPDATE, 40'd100);
		push(REQ_UPDATE, 40'd101);
		push(REQ_UPDATE, 40'd101);
		push(REQ_FRAME, 40'd1000000);
		settle();

		write_reg(CFG_MIN_INTERVAL, 20'd1);
		write_reg(CFG_UPDATE_PERIOD, 20'd1000000);
		push(REQ_UPDATE, 40'd10000);
		push(REQ_UPDATE, 40'd14999);
		push(REQ_UPDATE, 40'd2000000);
		push(REQ_CHECK, 40'd1500000);
		settle();

		// full-scale register values, and writes to unused indexes that must be ignored
		write_reg(CFG_MIN_INTERVAL, '1);
		write_reg(CFG_UPDATE_PERIOD, '1);
		write_reg(CFG_SPARE_LO, 20'd7);
		write_reg(CFG_SPARE_HI, '1);
		push(REQ_FRAME, 40'd2500000);
		push(REQ_UPDATE, 40'd3000000);
		push(REQ_CHECK, '0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
			0: period_pick = 20'd1;
			1: period_pick = 20'd1000000;
			2: period_pick = CFG_W'($urandom_range(1, 1000000));
			default: period_pick = CFG_W'($urandom_range(1000, 50000));
			endcase
			case ($urandom_range(0, 5))
			0: floor_pick = '0;
			1: floor_pick = 20'd1;
			2: floor_pick = CFG_W'($urandom_range(1, 1000000));
			default: floor_pick = CFG_W'($urandom_range(1000, 20000));
			endcase
			write_reg(CFG_UPDATE_PERIOD, period_pick);
			write_reg(CFG_MIN_INTERVAL, floor_pick);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					CFG_W'($urandom()));

			// start just short of the next scheduled update so due flips both ways
			t = (next_update_at > 60000) ? next_update_at - $urandom_range(0, 60000)
				: next_update_at;
			// about four in ten events are update marks, so this tracks the period
			step_max = (int'(period_pick) * 4) / 5;
			if (step_max < 1)
				step_max = 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					t = t + STAMP_W'($urandom_range(0, step_max));
					roll = $urandom_range(0, 99);
					if (roll < 40)
						push(REQ_UPDATE, t);
					else if (roll < 80)
						push(REQ_FRAME, t);
					else if (roll < 95)
						push(REQ_CHECK, t);
					else
						push(REQ_OTHER, t);
				end else begin
					// noise: any kind at any time, often far out of order
					wide = {$urandom(), $urandom()};
					push(erm_req_t'($urandom_range(0, 3)), wide[STAMP_W-1:0]);
				end
			end
			settle();
		end

		$display("%0d events (%0d update, %0d frame, %0d check) under %0d register writes",
			n_update + n_frame + n_check, n_update, n_frame, n_check, settings_used);
		$display("%0d readings compared, %0d with an update due, %0d at the rate ceiling",
			readings_checked, n_due, n_ceiling);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: timed out with %0d readings outstanding", $time,
			expected_readings.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
